// File: design/first_fit_block_allocator_macros.svh
// Assertion macros shared by the allocator RTL.
// Each check is sampled on the rising edge of clk_i and is off while rst_ni is low.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_MACROS_SVH

`ifndef NO_ASSERTIONS
// A property that must hold at every sampled edge.
`define FFBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// A condition that must never be seen.
`define FFBA_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define FFBA_ASSERT(lbl, prop, msg)
`define FFBA_NEVER(lbl, cond, msg)
`endif

`endif

// File: design/ffba_pkg.sv
`timescale 1ns / 1ps

package ffba_pkg;

  // Default sizing of the block table and the heap layout.
  localparam int MaxBlocksDef   = 16;
  localparam int HeaderBytesDef = 32;
  localparam int AlignBytesDef  = 8;

  // The alignment remainder is kept in seven bits, so it must stay below 128.
  localparam int RemW = 7;

  // Request opcodes.
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Result status codes.
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NULL    = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_LIMIT   = 3'd3;
  localparam logic [2:0] ST_UNKNOWN = 3'd4;

  // One entry of the block table.
  typedef struct packed {
    logic [31:0] start;
    logic [31:0] length;
    logic        used;
  } entry_t;

endpackage

// File: design/first_fit_block_allocator.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake                    Word
// in        input      in_valid_i / in_ready_o      opcode, request_size, free_address
// out       output     out_valid_o / out_ready_i    data_address, status, heap_grew
// cfg       input      APB psel/penable/pwrite      heap_start (0x0), heap_limit (0x4)
//
// One request at a time; the table memory is read one entry per cycle.
// Allocate scans the table from the highest entry down; a miss grows the heap, and
// the alignment remainder of the break uses one reciprocal multiply.
// Free searches the table upward, then each merge moves the later table entries down.
// The result sits in an output register, so the next request is taken while it waits.
// Reset is asynchronous and clears the table count and the break; the break is loaded
// from heap_start when heap_start is written while the table is empty.

module first_fit_block_allocator #(
  parameter int MAX_BLOCKS   = ffba_pkg::MaxBlocksDef,
  parameter int HEADER_BYTES = ffba_pkg::HeaderBytesDef,
  parameter int ALIGN_BYTES  = ffba_pkg::AlignBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        opcode_i,
  input  logic [31:0] request_size_i,
  input  logic [31:0] free_address_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] data_address_o,
  output logic [2:0]  status_o,
  output logic        heap_grew_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

`include "first_fit_block_allocator_macros.svh"

  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam int IW = $clog2(MAX_BLOCKS);
  localparam logic [32:0] Hdr33 = 33'(HEADER_BYTES);
  localparam logic [33:0] Hdr34 = 34'(HEADER_BYTES);
  localparam logic [7:0]  AlignW = 8'(ALIGN_BYTES);
  localparam logic [31:0] Align32 = 32'(ALIGN_BYTES);
  localparam logic [CW-1:0] MaxCnt = CW'(MAX_BLOCKS);
  localparam logic [CW-1:0] One = CW'(1);
  localparam logic [CW-1:0] Two = CW'(2);

  // Rounded-up reciprocal of the alignment; exact for every 32-bit break.
  localparam int RecK = 32 + $clog2(ALIGN_BYTES);
  localparam logic [63:0] RecipM =
    ((64'd1 << RecK) + 64'(ALIGN_BYTES) - 64'd1) / 64'(ALIGN_BYTES);
  localparam logic [32:0] Recip33 = RecipM[32:0];

  typedef enum logic [3:0] {
    S_IDLE, S_A_CHK, S_A_GROW, S_A_DIV, S_A_REM, S_A_START, S_A_END,
    S_F_CHK, S_F_NCHK, S_SHIFT, S_F_WCUR, S_F_PCHK, S_DONE
  } state_e;

  state_e state_q;
  logic [CW-1:0] count_q, pos_q, idx_q;
  logic [31:0] brk_q, hs_q, hl_q, size_q, addr_q;
  logic [31:0] cur_start_q, cur_len_q;
  logic        phase_q;
  logic [ffba_pkg::RemW-1:0] rem_q;
  logic [31:0] quo_q;
  logic [32:0] start_q;
  logic [31:0] res_addr_q;
  logic [2:0]  res_st_q;
  logic        res_grew_q;
  logic        out_valid_q;
  logic [31:0] out_addr_q;
  logic [2:0]  out_st_q;
  logic        out_grew_q;

  // Table memory with registered read data.
  ffba_pkg::entry_t mem [MAX_BLOCKS];
  ffba_pkg::entry_t rd_q;
  ffba_pkg::entry_t wd;
  logic [CW-1:0] rd_addr, wa;
  logic          we;

  // Shared datapath terms.
  logic        fit, more, over, in_acc, cfg_wr;
  logic [64:0] recip_prod;
  logic [32:0] pad;
  logic [33:0] end34;

  assign in_acc     = in_valid_i && in_ready_o;
  assign cfg_wr     = psel && penable && pwrite && pready;
  assign fit        = !rd_q.used && (rd_q.length >= size_q);
  assign more       = (pos_q + One) < count_q;
  assign recip_prod = 65'(brk_q) * 65'(Recip33);
  assign pad        = (rem_q == '0) ? 33'd0 : 33'(AlignW - {1'b0, rem_q});
  assign end34      = {1'b0, start_q} + Hdr34 + {2'b0, size_q};
  assign over       = end34 > {2'b0, hl_q};

  // Memory address and write control for each sequencer step.
  always_comb begin
    rd_addr = pos_q;
    we      = 1'b0;
    wa      = pos_q;
    wd      = rd_q;
    case (state_q)
      S_IDLE: begin
        rd_addr = (opcode_i == ffba_pkg::OP_FREE) ? '0 : count_q - One;
      end
      S_A_CHK: begin
        if (fit) begin
          we      = 1'b1;
          wd.used = 1'b1;
        end else begin
          rd_addr = pos_q - One;
        end
      end
      S_F_CHK: rd_addr = pos_q + One;
      S_F_NCHK: rd_addr = idx_q + Two;
      S_SHIFT: begin
        rd_addr = pos_q + Two;
        we      = more;
      end
      S_F_WCUR: begin
        we      = 1'b1;
        wa      = idx_q;
        wd      = '{start: cur_start_q, length: cur_len_q, used: 1'b0};
        rd_addr = idx_q - One;
      end
      S_F_PCHK: begin
        rd_addr = idx_q + One;
        if (idx_q != '0 && !rd_q.used) begin
          we        = 1'b1;
          wa        = idx_q - One;
          wd.length = cur_start_q - rd_q.start + cur_len_q;
          wd.used   = 1'b0;
        end
      end
      S_A_END: begin
        wa = count_q;
        we = !over;
        wd = '{start: start_q[31:0], length: size_q, used: 1'b1};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa[IW-1:0]] <= wd;
    end
    rd_q <= mem[rd_addr[IW-1:0]];
  end

  // Sequencer, configuration registers and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      brk_q       <= '0;
      hs_q        <= '0;
      hl_q        <= '1;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_wr) begin
        if (paddr[2] == 1'b0) begin
          hs_q <= pwdata;
          if (count_q == '0) begin
            brk_q <= pwdata;
          end
        end else begin
          hl_q <= pwdata;
        end
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            size_q     <= request_size_i;
            addr_q     <= free_address_i;
            res_addr_q <= '0;
            res_st_q   <= ffba_pkg::ST_OK;
            res_grew_q <= 1'b0;
            pos_q      <= '0;
            if (opcode_i == ffba_pkg::OP_FREE) begin
              if (free_address_i == '0) begin
                res_st_q <= ffba_pkg::ST_NULL;
                state_q  <= S_DONE;
              end else if (count_q == '0) begin
                res_st_q <= ffba_pkg::ST_UNKNOWN;
                state_q  <= S_DONE;
              end else begin
                state_q <= S_F_CHK;
              end
            end else if (request_size_i == '0) begin
              res_st_q <= ffba_pkg::ST_NULL;
              state_q  <= S_DONE;
            end else if (count_q == '0) begin
              state_q <= S_A_GROW;
            end else begin
              pos_q   <= count_q - One;
              state_q <= S_A_CHK;
            end
          end
        end
        // Scan from the highest block down for the first free fit.
        S_A_CHK: begin
          if (fit) begin
            res_addr_q <= 32'({1'b0, rd_q.start} + Hdr33);
            state_q    <= S_DONE;
          end else if (pos_q != '0) begin
            pos_q <= pos_q - One;
          end else begin
            state_q <= S_A_GROW;
          end
        end
        S_A_GROW: begin
          if (count_q >= MaxCnt) begin
            res_st_q <= ffba_pkg::ST_FULL;
            state_q  <= S_DONE;
          end else begin
            state_q <= S_A_DIV;
          end
        end
        // Quotient of the break by the alignment through the reciprocal.
        S_A_DIV: begin
          quo_q   <= 32'(recip_prod >> RecK);
          state_q <= S_A_REM;
        end
        // Remainder of the break from the quotient.
        S_A_REM: begin
          rem_q   <= ffba_pkg::RemW'(brk_q - 32'(quo_q * Align32));
          state_q <= S_A_START;
        end
        S_A_START: begin
          start_q <= {1'b0, brk_q} + pad;
          state_q <= S_A_END;
        end
        S_A_END: begin
          if (over) begin
            res_st_q <= ffba_pkg::ST_LIMIT;
          end else begin
            count_q    <= count_q + One;
            brk_q      <= end34[31:0];
            res_addr_q <= 32'(start_q + Hdr33);
            res_grew_q <= 1'b1;
          end
          state_q <= S_DONE;
        end
        // Search upward for the block whose data start matches.
        S_F_CHK: begin
          if (({1'b0, rd_q.start} + Hdr33) == {1'b0, addr_q}) begin
            idx_q       <= pos_q;
            cur_start_q <= rd_q.start;
            cur_len_q   <= rd_q.length;
            state_q     <= S_F_NCHK;
          end else if (more) begin
            pos_q <= pos_q + One;
          end else begin
            res_st_q <= ffba_pkg::ST_UNKNOWN;
            state_q  <= S_DONE;
          end
        end
        // Merge with a free next neighbor.
        S_F_NCHK: begin
          if ((idx_q + One) < count_q && !rd_q.used) begin
            cur_len_q <= rd_q.start - cur_start_q + rd_q.length;
            pos_q     <= idx_q + One;
            phase_q   <= 1'b0;
            state_q   <= S_SHIFT;
          end else begin
            state_q <= S_F_WCUR;
          end
        end
        // Close the gap left by a merged entry.
        S_SHIFT: begin
          if (more) begin
            pos_q <= pos_q + One;
          end else begin
            count_q <= count_q - One;
            state_q <= phase_q ? S_DONE : S_F_WCUR;
          end
        end
        S_F_WCUR: begin
          state_q <= (idx_q == '0) ? S_DONE : S_F_PCHK;
        end
        // Merge with a free previous neighbor.
        S_F_PCHK: begin
          if (!rd_q.used) begin
            pos_q   <= idx_q;
            phase_q <= 1'b1;
            state_q <= S_SHIFT;
          end else begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            out_addr_q  <= res_addr_q;
            out_st_q    <= res_st_q;
            out_grew_q  <= res_grew_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o     = (state_q == S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign data_address_o = out_addr_q;
  assign status_o       = out_st_q;
  assign heap_grew_o    = out_grew_q;
  assign pready         = 1'b1;
  assign prdata         = paddr[2] ? hl_q : hs_q;

  // Checks on the table bookkeeping and the result word.
  `FFBA_NEVER(a_count_max, count_q > MaxCnt, "block count exceeds table depth")
  `FFBA_ASSERT(a_fail_zero, (out_valid_o && status_o != ffba_pkg::ST_OK) |-> (data_address_o == '0), "failed request returned an address")
  `FFBA_ASSERT(a_grew_ok, (out_valid_o && heap_grew_o) |-> (status_o == ffba_pkg::ST_OK), "growth flagged on a failed request")
  `FFBA_ASSERT(a_busy, in_acc |=> !in_ready_o, "ready while a request is in progress")

endmodule
